[src/bed_pkg.sv]
// ----------------------------------------------------------------------------
// Button event detector package
// Shared widths, register indexes, event codes, state codes and structs.
// ----------------------------------------------------------------------------
package bed_pkg;

	// Fixed field widths.
	localparam int ENTRY_IDX_W   = 2;
	localparam int CODE_W        = 3;
	localparam int CLICK_W       = 4;
	localparam int CLICK_MAX     = (1 << CLICK_W) - 1;
	localparam int REG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;
	localparam int NUM_MASK_REGS = 4;
	localparam int MASK_CFG_BITS = 3;
	localparam int TICK_W        = 16;
	localparam int RUN_W         = 8;
	localparam int HOLD_W        = 8;
	localparam int STATE_W       = 3;

	// Per-entry click state machine codes.
	localparam logic [STATE_W-1:0] ST_IDLE    = 3'd0;
	localparam logic [STATE_W-1:0] ST_PRESS   = 3'd1;
	localparam logic [STATE_W-1:0] ST_RELEASE = 3'd2;
	localparam logic [STATE_W-1:0] ST_REPEAT  = 3'd3;
	localparam logic [STATE_W-1:0] ST_LONG    = 3'd4;

	// Event codes.
	localparam logic [CODE_W-1:0] EV_DOWN       = 3'd0;
	localparam logic [CODE_W-1:0] EV_UP         = 3'd1;
	localparam logic [CODE_W-1:0] EV_REPEAT     = 3'd2;
	localparam logic [CODE_W-1:0] EV_SINGLE     = 3'd3;
	localparam logic [CODE_W-1:0] EV_DOUBLE     = 3'd4;
	localparam logic [CODE_W-1:0] EV_LONG_PRESS = 3'd5;
	localparam logic [CODE_W-1:0] EV_LONG_HOLD  = 3'd6;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_ENTRY_MASK_0    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE_COUNT  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_LONG_PRESS      = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_CLICK_WINDOW    = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_HOLD_INTERVAL   = 3'd7;

	// Register reset values.
	localparam logic [7:0]  RST_DEBOUNCE_COUNT = 8'd3;
	localparam logic [15:0] RST_LONG_PRESS     = 16'd100;
	localparam logic [15:0] RST_CLICK_WINDOW   = 16'd30;
	localparam logic [7:0]  RST_HOLD_INTERVAL  = 8'd10;

	// Shared timing settings.
	typedef struct packed {
		logic [7:0]  debounce_count;
		logic [15:0] long_press_ticks;
		logic [15:0] click_window_ticks;
		logic [7:0]  hold_interval_ticks;
	} bed_cfg_t;

	// One word of the per-entry state table.
	typedef struct packed {
		logic [STATE_W-1:0] fsm_state;
		logic [TICK_W-1:0]  tick_count;
		logic [CLICK_W-1:0] press_count;
		logic [RUN_W-1:0]   debounce_run;
		logic [HOLD_W-1:0]  hold_countdown;
		logic               combo_suppressed;
	} bed_ent_t;

	// Events raised by one entry on one tick.
	typedef struct packed {
		logic [1:0]         num_events;
		logic [CODE_W-1:0]  code_0;
		logic [CODE_W-1:0]  code_1;
		logic [CLICK_W-1:0] click_count;
	} bed_evset_t;

endpackage

[src/bed_if.sv]
// ----------------------------------------------------------------------------
// Button event detector channels
// Valid/ready channels for key samples, events and register writes.
// ----------------------------------------------------------------------------
interface bed_key_if #(parameter int NKEYS = 3) ();
	logic             valid;
	logic             ready;
	logic [NKEYS-1:0] raw_keys;

	modport source(output valid, output raw_keys, input ready);
	modport sink(input valid, input raw_keys, output ready);
endinterface

interface bed_evt_if ();
	logic                        valid;
	logic                        ready;
	logic [bed_pkg::ENTRY_IDX_W-1:0] entry_index;
	logic [bed_pkg::CODE_W-1:0]  event_code;
	logic [bed_pkg::CLICK_W-1:0] click_count;
	logic                        last_event;

	modport source(output valid, output entry_index, output event_code,
		output click_count, output last_event, input ready);
	modport sink(input valid, input entry_index, input event_code,
		input click_count, input last_event, output ready);
endinterface

interface bed_cfg_if ();
	logic                           valid;
	logic                           ready;
	logic [bed_pkg::REG_IDX_W-1:0]  index;
	logic [bed_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

[src/bed_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Button event detector configuration registers
// Holds the entry key masks and the timing settings.
// ----------------------------------------------------------------------------
module bed_cfg_regs #(
	parameter int NUM_ENTRIES = 4,
	parameter int NUM_KEYS    = 3
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	bed_cfg_if.sink                               wr,
	output logic [NUM_ENTRIES-1:0][NUM_KEYS-1:0]  masks,
	output bed_pkg::bed_cfg_t                     regs
);
	import bed_pkg::*;

	logic [NUM_KEYS-1:0] mask_val;

	// Writes are always taken.
	assign wr.ready = 1'b1;

	// Only the low key bits of a mask write are kept.
	always_comb begin
		for (int k = 0; k < NUM_KEYS; k++) begin
			mask_val[k] = (k < MASK_CFG_BITS) ? wr.data[k] : 1'b0;
		end
	end

	// Register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			masks                    <= '0;
			regs.debounce_count      <= RST_DEBOUNCE_COUNT;
			regs.long_press_ticks    <= RST_LONG_PRESS;
			regs.click_window_ticks  <= RST_CLICK_WINDOW;
			regs.hold_interval_ticks <= RST_HOLD_INTERVAL;
		end else if (wr.valid) begin
			case (wr.index)
				REG_DEBOUNCE_COUNT: regs.debounce_count      <= wr.data[7:0];
				REG_LONG_PRESS:     regs.long_press_ticks    <= wr.data;
				REG_CLICK_WINDOW:   regs.click_window_ticks  <= wr.data;
				REG_HOLD_INTERVAL:  regs.hold_interval_ticks <= wr.data[7:0];
				default: ;
			endcase
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				if (i < NUM_MASK_REGS && wr.index == REG_ENTRY_MASK_0 + REG_IDX_W'(i)) begin
					masks[i] <= mask_val;
				end
			end
		end
	end

endmodule

[src/bed_entry_upd.sv]
// ----------------------------------------------------------------------------
// Button event detector entry update
// Debounce and click state machine step for one entry on one tick.
// ----------------------------------------------------------------------------
module bed_entry_upd #(
	parameter int NUM_KEYS     = 3,
	parameter int REPEAT_LIMIT = 15
) (
	input  bed_pkg::bed_ent_t    cur_ent,
	input  logic                 cur_stable,
	input  logic [NUM_KEYS-1:0]  mask,
	input  logic [NUM_KEYS-1:0]  keys,
	input  bed_pkg::bed_cfg_t    cfg,
	input  logic                 covered,
	output bed_pkg::bed_ent_t    nxt_ent,
	output logic                 nxt_stable,
	output bed_pkg::bed_evset_t  evs
);
	import bed_pkg::*;

	localparam int PRESS_CAP = (REPEAT_LIMIT < CLICK_MAX) ? REPEAT_LIMIT : CLICK_MAX;

	logic              raw;
	logic              lvl;
	logic [RUN_W-1:0]  run_inc;
	logic [TICK_W-1:0] tick_inc;
	logic [HOLD_W-1:0] hold_dec;

	// Saturating counters ahead of the state machine.
	assign raw      = (keys & mask) == mask;
	assign run_inc  = cur_ent.debounce_run + RUN_W'(cur_ent.debounce_run != '1);
	assign tick_inc = cur_ent.tick_count +
		TICK_W'(cur_ent.fsm_state != ST_IDLE && cur_ent.tick_count != '1);
	assign hold_dec = cur_ent.hold_countdown - HOLD_W'(cur_ent.hold_countdown != '0);

	// Debounce, then the click state machine.
	always_comb begin
		nxt_ent                = cur_ent;
		nxt_ent.tick_count     = tick_inc;
		nxt_ent.hold_countdown = hold_dec;
		lvl                    = cur_stable;
		evs                    = '0;

		if (raw != cur_stable) begin
			if (run_inc >= cfg.debounce_count) begin
				lvl                  = raw;
				nxt_ent.debounce_run = '0;
			end else begin
				nxt_ent.debounce_run = run_inc;
			end
		end else begin
			nxt_ent.debounce_run = '0;
		end

		case (cur_ent.fsm_state)
			ST_IDLE: begin
				if (lvl) begin
					nxt_ent.press_count      = CLICK_W'(1);
					evs.num_events           = 2'd1;
					evs.code_0               = EV_DOWN;
					nxt_ent.tick_count       = '0;
					nxt_ent.combo_suppressed = 1'b0;
					nxt_ent.fsm_state        = ST_PRESS;
				end
			end
			ST_PRESS: begin
				if (!lvl) begin
					evs.num_events     = 2'd1;
					evs.code_0         = EV_UP;
					nxt_ent.tick_count = '0;
					nxt_ent.fsm_state  = ST_RELEASE;
				end else if (tick_inc > cfg.long_press_ticks) begin
					evs.num_events         = 2'd1;
					evs.code_0             = EV_LONG_PRESS;
					nxt_ent.hold_countdown = '0;
					nxt_ent.fsm_state      = ST_LONG;
				end
			end
			ST_RELEASE: begin
				if (lvl) begin
					if (cur_ent.press_count < CLICK_W'(PRESS_CAP)) begin
						nxt_ent.press_count = cur_ent.press_count + CLICK_W'(1);
					end
					evs.num_events     = 2'd2;
					evs.code_0         = EV_DOWN;
					evs.code_1         = EV_REPEAT;
					nxt_ent.tick_count = '0;
					nxt_ent.fsm_state  = ST_REPEAT;
				end else if (tick_inc > cfg.click_window_ticks) begin
					// A combo that covered this entry swallows its click result.
					if (cur_ent.combo_suppressed) begin
						nxt_ent.combo_suppressed = 1'b0;
					end else if (cur_ent.press_count == CLICK_W'(1)) begin
						evs.num_events = 2'd1;
						evs.code_0     = EV_SINGLE;
					end else if (cur_ent.press_count == CLICK_W'(2)) begin
						evs.num_events = 2'd1;
						evs.code_0     = EV_DOUBLE;
					end
					nxt_ent.fsm_state = ST_IDLE;
				end
			end
			ST_REPEAT: begin
				if (!lvl) begin
					evs.num_events = 2'd1;
					evs.code_0     = EV_UP;
					if (tick_inc < cfg.click_window_ticks) begin
						nxt_ent.tick_count = '0;
						nxt_ent.fsm_state  = ST_RELEASE;
					end else begin
						nxt_ent.fsm_state = ST_IDLE;
					end
				end else if (tick_inc > cfg.click_window_ticks) begin
					nxt_ent.fsm_state = ST_PRESS;
				end
			end
			ST_LONG: begin
				if (lvl) begin
					if (hold_dec == '0) begin
						evs.num_events         = 2'd1;
						evs.code_0             = EV_LONG_HOLD;
						nxt_ent.hold_countdown = cfg.hold_interval_ticks;
					end
				end else begin
					evs.num_events    = 2'd1;
					evs.code_0        = EV_UP;
					nxt_ent.fsm_state = ST_IDLE;
				end
			end
			default: begin
				nxt_ent.fsm_state = ST_IDLE;
			end
		endcase

		if (lvl && covered) begin
			nxt_ent.combo_suppressed = 1'b1;
		end

		evs.click_count = nxt_ent.press_count;
		nxt_stable      = lvl;
	end

endmodule

[src/bed_seq.sv]
// ----------------------------------------------------------------------------
// Button event detector sequencer
// Walks the entries of one tick through the state table and emits events.
// ----------------------------------------------------------------------------
module bed_seq #(
	parameter int NUM_ENTRIES  = 4,
	parameter int NUM_KEYS     = 3,
	parameter int REPEAT_LIMIT = 15
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	bed_key_if.sink                              keys,
	bed_evt_if.source                            events,
	input  logic [NUM_ENTRIES-1:0][NUM_KEYS-1:0] masks,
	input  bed_pkg::bed_cfg_t                    regs
);
	import bed_pkg::*;

	localparam int EW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam logic [EW-1:0] LAST_ENTRY = EW'(NUM_ENTRIES - 1);

	// Sequencer states.
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_READ  = 3'd1;
	localparam logic [2:0] S_EXEC  = 3'd2;
	localparam logic [2:0] S_PUSH  = 3'd3;
	localparam logic [2:0] S_FLUSH = 3'd4;

	logic [2:0]             state_q;
	logic [EW-1:0]          ent_q;
	logic [NUM_KEYS-1:0]    keys_q;
	logic [NUM_ENTRIES-1:0] vld_q;
	logic [NUM_ENTRIES-1:0] stable_q;
	bed_ent_t               mem [NUM_ENTRIES];
	bed_ent_t               rd_q;
	logic                   rd_vld_q;
	bed_evset_t             evs_q;
	logic [1:0]             ev_cnt_q;

	logic                   pend_v_q;
	logic [ENTRY_IDX_W-1:0] pend_idx_q;
	logic [CODE_W-1:0]      pend_code_q;
	logic [CLICK_W-1:0]     pend_click_q;

	logic                   out_v_q;
	logic [ENTRY_IDX_W-1:0] out_idx_q;
	logic [CODE_W-1:0]      out_code_q;
	logic [CLICK_W-1:0]     out_click_q;
	logic                   out_last_q;

	logic [NUM_KEYS-1:0]    cur_mask;
	logic [NUM_ENTRIES-1:0] hit;
	logic                   covered;
	bed_ent_t               cur_ent;
	bed_ent_t               nxt_ent;
	logic                   nxt_stable;
	bed_evset_t             evs;
	logic                   out_free;
	logic                   out_load;
	logic                   ev_done;
	logic                   ev_move;
	logic [CODE_W-1:0]      ev_code;
	logic [ENTRY_IDX_W+EW-1:0] idx_ext;
	logic [ENTRY_IDX_W-1:0] cur_idx;

	assign cur_mask = masks[ent_q];
	assign cur_ent  = rd_vld_q ? rd_q : '0;
	assign idx_ext  = {{ENTRY_IDX_W{1'b0}}, ent_q};
	assign cur_idx  = idx_ext[ENTRY_IDX_W-1:0];

	// A held multi-key entry whose mask strictly covers this one.
	always_comb begin
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			hit[i] = (masks[i] != '0) && ((masks[i] & (masks[i] - NUM_KEYS'(1))) != '0) &&
				(masks[i] != cur_mask) && ((cur_mask & masks[i]) == cur_mask) && stable_q[i];
		end
	end
	assign covered = |hit;

	bed_entry_upd #(
		.NUM_KEYS     (NUM_KEYS),
		.REPEAT_LIMIT (REPEAT_LIMIT)
	) u_upd (
		.cur_ent    (cur_ent),
		.cur_stable (stable_q[ent_q]),
		.mask       (cur_mask),
		.keys       (keys_q),
		.cfg        (regs),
		.covered    (covered),
		.nxt_ent    (nxt_ent),
		.nxt_stable (nxt_stable),
		.evs        (evs)
	);

	// Event hand-off: the newest event waits in a hold slot until the next
	// one, or the end of the tick, tells whether it is the last.
	assign out_free = !out_v_q || events.ready;
	assign ev_done  = ev_cnt_q == evs_q.num_events;
	assign ev_code  = (ev_cnt_q == 2'd0) ? evs_q.code_0 : evs_q.code_1;
	assign ev_move  = (state_q == S_PUSH) && !ev_done && (!pend_v_q || out_free);
	assign out_load = (ev_move && pend_v_q) || (state_q == S_FLUSH && pend_v_q && out_free);

	assign keys.ready         = state_q == S_IDLE;
	assign events.valid       = out_v_q;
	assign events.entry_index = out_idx_q;
	assign events.event_code  = out_code_q;
	assign events.click_count = out_click_q;
	assign events.last_event  = out_last_q;

	// State table, read through a register in the state before the update.
	always_ff @(posedge clk) begin
		rd_q <= mem[ent_q];
		if (state_q == S_EXEC) begin
			mem[ent_q] <= nxt_ent;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			keys_q <= keys.raw_keys;
		end
		if (state_q == S_EXEC) begin
			evs_q <= evs;
		end
		if (ev_move) begin
			pend_idx_q   <= cur_idx;
			pend_code_q  <= ev_code;
			pend_click_q <= evs_q.click_count;
		end
		if (out_load) begin
			out_idx_q   <= pend_idx_q;
			out_code_q  <= pend_code_q;
			out_click_q <= pend_click_q;
			out_last_q  <= state_q == S_FLUSH;
		end
	end

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ent_q    <= '0;
			vld_q    <= '0;
			stable_q <= '0;
			rd_vld_q <= 1'b0;
			ev_cnt_q <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[ent_q];
			// The output register fills when the hold slot moves on and
			// empties when its beat is taken.
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (events.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (keys.valid) begin
						ent_q   <= '0;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (cur_mask != '0) begin
						state_q <= S_EXEC;
					end else if (ent_q == LAST_ENTRY) begin
						state_q <= S_FLUSH;
					end else begin
						ent_q <= ent_q + EW'(1);
					end
				end
				S_EXEC: begin
					vld_q[ent_q]    <= 1'b1;
					stable_q[ent_q] <= nxt_stable;
					ev_cnt_q        <= '0;
					state_q         <= S_PUSH;
				end
				S_PUSH: begin
					if (ev_done) begin
						if (ent_q == LAST_ENTRY) begin
							state_q <= S_FLUSH;
						end else begin
							ent_q   <= ent_q + EW'(1);
							state_q <= S_READ;
						end
					end else if (ev_move) begin
						ev_cnt_q <= ev_cnt_q + 2'd1;
						pend_v_q <= 1'b1;
					end
				end
				S_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[src/button_event_detector_top.sv]
// ----------------------------------------------------------------------------
// Button event detector
// Debounces key combinations and reports click and long press events.
// ----------------------------------------------------------------------------
// Each accepted key sample is one scan tick. The block then visits every
// logical entry in index order: a disabled entry passes through the read
// state alone, an enabled one through state table read, update and write
// back, and event check, and each event it raises is moved out in the event
// check state, which waits while the event path is full. The tick ends with a
// flush state to release the final event and an idle state in which the next
// sample can be taken; the next sample is taken only once the tick is done.
// The per-entry state lives in one small table with a registered read; each
// entry has a valid bit cleared by reset, so no clearing pass is needed.
// Events leave through an output register, so a stalled consumer holds up
// the scan only when a new event needs the register.
module button_event_detector_top #(
	parameter int NUM_ENTRIES  = 4,
	parameter int NUM_KEYS     = 3,
	parameter int REPEAT_LIMIT = 15
) (
	input  logic      clk,
	input  logic      arst_n,
	bed_key_if.sink   keys,
	bed_evt_if.source events,
	bed_cfg_if.sink   cfg
);
	import bed_pkg::*;

	logic [NUM_ENTRIES-1:0][NUM_KEYS-1:0] masks;
	bed_cfg_t                             regs;

	// Configuration registers.
	bed_cfg_regs #(
		.NUM_ENTRIES (NUM_ENTRIES),
		.NUM_KEYS    (NUM_KEYS)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg),
		.masks  (masks),
		.regs   (regs)
	);

	// Entry scan and event output.
	bed_seq #(
		.NUM_ENTRIES  (NUM_ENTRIES),
		.NUM_KEYS     (NUM_KEYS),
		.REPEAT_LIMIT (REPEAT_LIMIT)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.keys   (keys),
		.events (events),
		.masks  (masks),
		.regs   (regs)
	);

endmodule

[src/bed_chk.sv]
// ----------------------------------------------------------------------------
// Button event detector checker
// Port-level checks, attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
module bed_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         keys_valid,
	input logic                         keys_ready,
	input logic                         ev_valid,
	input logic                         ev_ready,
	input logic [bed_pkg::CODE_W-1:0]   ev_code,
	input logic [bed_pkg::CLICK_W-1:0]  ev_click,
	input logic                         ev_last
);
	import bed_pkg::*;

	// A tick keeps the block busy for at least the cycle after its sample.
	a_busy_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		keys_valid && keys_ready |=> !keys_ready)
		else $error("key sample taken on two cycles in a row");

	// A stalled event beat holds its contents.
	a_event_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && !ev_ready |=> ev_valid && $stable(ev_code) && $stable(ev_click) &&
			$stable(ev_last))
		else $error("stalled event beat changed");

	// Only defined event codes are reported.
	a_event_code: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid |-> ev_code <= EV_LONG_HOLD)
		else $error("undefined event code");

	// Every event belongs to a sequence that has seen at least one press.
	a_click_count: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid |-> ev_click != '0)
		else $error("event with zero press count");

endmodule

bind button_event_detector_top bed_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.keys_valid (keys.valid),
	.keys_ready (keys.ready),
	.ev_valid   (events.valid),
	.ev_ready   (events.ready),
	.ev_code    (events.event_code),
	.ev_click   (events.click_count),
	.ev_last    (events.last_event)
);

[tb/button_event_detector_top_tb.sv]
// ----------------------------------------------------------------------------
// Button event detector testbench
// Drives scan ticks of raw key bits into the detector and checks every event
// beat against a cycle-free model of the debounce and click state machines.
// Timing registers and entry masks are rewritten between phases while the
// block is quiet. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module button_event_detector_top_tb;
	import bed_pkg::*;

	localparam int NUM_ENT   = 4;
	localparam int PRESS_CAP = 15;
	localparam int SETTLE    = 40;
	localparam int LIMIT     = 400000;

	// One expected or observed event beat.
	typedef struct packed {
		logic [ENTRY_IDX_W-1:0] entry;
		logic [CODE_W-1:0]      code;
		logic [CLICK_W-1:0]     clicks;
		logic                   last;
	} key_event_t;

	// One scan tick waiting to be sent.
	typedef struct {
		logic [2:0] keys;
		int         gap;
		bit         drain;
	} scan_item_t;

	logic clk;
	logic arst_n;

	bed_key_if #(.NKEYS(3)) key_ch ();
	bed_evt_if              ev_ch ();
	bed_cfg_if              cfg_ch ();

	button_event_detector_top #(
		.NUM_ENTRIES(NUM_ENT),
		.NUM_KEYS(3),
		.REPEAT_LIMIT(15)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.keys(key_ch),
		.events(ev_ch),
		.cfg(cfg_ch)
	);

	// Shadow copy of the configuration registers.
	logic [2:0]  mask_r [NUM_ENT];
	logic [7:0]  deb_cnt;
	logic [15:0] lp_ticks;
	logic [15:0] cw_ticks;
	logic [7:0]  hold_iv;

	// Shadow copy of the per-entry state.
	logic [STATE_W-1:0] ent_state [NUM_ENT];
	logic [15:0]        held_ticks [NUM_ENT];
	logic [3:0]         presses [NUM_ENT];
	logic [7:0]         bounce_run [NUM_ENT];
	logic               settled [NUM_ENT];
	logic [7:0]         hold_left [NUM_ENT];
	logic               combo_mute [NUM_ENT];

	key_event_t pending_events [$];
	scan_item_t scan_q [$];
	scan_item_t staged;
	bit         staged_ok;
	bit         idle_on;
	bit         stall_on;
	int         stall_left;
	int         stall_next;
	int         errors;
	int         ticks_sent;
	int         events_seen;
	int         cfg_writes;
	int         cycles;
	key_event_t seen;
	key_event_t want;

	// Clock.
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic key_event_t make_event(input int e, input logic [CODE_W-1:0] code);
		key_event_t ev;
		ev.entry  = e[ENTRY_IDX_W-1:0];
		ev.code   = code;
		ev.clicks = '0;
		ev.last   = 1'b0;
		return ev;
	endfunction

	// Works out the events of one scan tick and queues them as expectations.
	function automatic void scan_tick(input logic [2:0] raw_in);
		key_event_t burst [$];
		logic [2:0] mine;
		logic [2:0] c;
		logic       raw_lvl;
		logic       lvl;
		logic       covered;
		int         first;
		for (int e = 0; e < NUM_ENT; e++) begin
			if (mask_r[e] != 3'b000) begin
				mine    = mask_r[e];
				raw_lvl = ((raw_in & mine) == mine);
				first   = burst.size();

				if (ent_state[e] != ST_IDLE && held_ticks[e] != 16'hFFFF)
					held_ticks[e] = held_ticks[e] + 16'd1;
				if (hold_left[e] != 8'd0)
					hold_left[e] = hold_left[e] - 8'd1;

				// Debounce: accept a new level after enough differing samples.
				if (raw_lvl != settled[e]) begin
					if (bounce_run[e] != 8'hFF)
						bounce_run[e] = bounce_run[e] + 8'd1;
					if (bounce_run[e] >= deb_cnt) begin
						settled[e]    = raw_lvl;
						bounce_run[e] = 8'd0;
					end
				end else begin
					bounce_run[e] = 8'd0;
				end
				lvl = settled[e];

				// Click and long press state machine.
				case (ent_state[e])
					ST_IDLE: begin
						if (lvl) begin
							presses[e] = 4'd1;
							burst.push_back(make_event(e, EV_DOWN));
							held_ticks[e] = 16'd0;
							combo_mute[e] = 1'b0;
							ent_state[e]  = ST_PRESS;
						end
					end
					ST_PRESS: begin
						if (!lvl) begin
							burst.push_back(make_event(e, EV_UP));
							held_ticks[e] = 16'd0;
							ent_state[e]  = ST_RELEASE;
						end else if (held_ticks[e] > lp_ticks) begin
							burst.push_back(make_event(e, EV_LONG_PRESS));
							hold_left[e] = 8'd0;
							ent_state[e] = ST_LONG;
						end
					end
					ST_RELEASE: begin
						if (lvl) begin
							if (presses[e] < PRESS_CAP)
								presses[e] = presses[e] + 4'd1;
							burst.push_back(make_event(e, EV_DOWN));
							burst.push_back(make_event(e, EV_REPEAT));
							held_ticks[e] = 16'd0;
							ent_state[e]  = ST_REPEAT;
						end else if (held_ticks[e] > cw_ticks) begin
							if (combo_mute[e])
								combo_mute[e] = 1'b0;
							else if (presses[e] == 4'd1)
								burst.push_back(make_event(e, EV_SINGLE));
							else if (presses[e] == 4'd2)
								burst.push_back(make_event(e, EV_DOUBLE));
							ent_state[e] = ST_IDLE;
						end
					end
					ST_REPEAT: begin
						if (!lvl) begin
							burst.push_back(make_event(e, EV_UP));
							if (held_ticks[e] < cw_ticks) begin
								held_ticks[e] = 16'd0;
								ent_state[e]  = ST_RELEASE;
							end else begin
								ent_state[e] = ST_IDLE;
							end
						end else if (held_ticks[e] > cw_ticks) begin
							ent_state[e] = ST_PRESS;
						end
					end
					ST_LONG: begin
						if (lvl) begin
							if (hold_left[e] == 8'd0) begin
								burst.push_back(make_event(e, EV_LONG_HOLD));
								hold_left[e] = hold_iv;
							end
						end else begin
							burst.push_back(make_event(e, EV_UP));
							ent_state[e] = ST_IDLE;
						end
					end
					default: ent_state[e] = ST_IDLE;
				endcase

				// A held combo whose mask strictly covers this one mutes the click.
				covered = 1'b0;
				for (int i = 0; i < NUM_ENT; i++) begin
					c = mask_r[i];
					if (c != 3'b000 && (c & (c - 3'd1)) != 3'b000 && c != mine &&
						(mine & c) == mine && settled[i])
						covered = 1'b1;
				end
				if (lvl && covered)
					combo_mute[e] = 1'b1;

				for (int k = first; k < burst.size(); k++)
					burst[k].clicks = presses[e];
			end
		end
		if (burst.size() != 0)
			burst[burst.size() - 1].last = 1'b1;
		foreach (burst[k])
			pending_events.push_back(burst[k]);
	endfunction

	// Scan tick driver: presents queued ticks with their drawn gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_ch.valid    <= 1'b0;
			key_ch.raw_keys <= 3'b000;
		end else begin
			if (key_ch.valid && key_ch.ready) begin
				scan_tick(key_ch.raw_keys);
				ticks_sent++;
			end
			if (!key_ch.valid || key_ch.ready) begin
				if (!staged_ok && scan_q.size() != 0) begin
					staged    = scan_q.pop_front();
					staged_ok = 1'b1;
				end
				if (staged_ok && staged.drain && pending_events.size() != 0) begin
					key_ch.valid <= 1'b0;
				end else if (staged_ok && staged.gap > 0) begin
					staged.gap--;
					key_ch.valid <= 1'b0;
				end else if (staged_ok) begin
					key_ch.valid    <= 1'b1;
					key_ch.raw_keys <= staged.keys;
					staged_ok = 1'b0;
				end else begin
					key_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Event monitor: checks each beat against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_ch.ready <= 1'b0;
			stall_left  <= 0;
		end else begin
			if (ev_ch.valid && ev_ch.ready) begin
				events_seen++;
				seen.entry  = ev_ch.entry_index;
				seen.code   = ev_ch.event_code;
				seen.clicks = ev_ch.click_count;
				seen.last   = ev_ch.last_event;
				if (pending_events.size() == 0) begin
					errors++;
					$display("%0t: unexpected event beat: entry %0d code %0d clicks %0d last %0d",
						$time, seen.entry, seen.code, seen.clicks, seen.last);
				end else begin
					want = pending_events.pop_front();
					if (seen != want) begin
						errors++;
						$display("%0t: event mismatch: expected entry %0d code %0d clicks %0d last %0d",
							$time, want.entry, want.code, want.clicks, want.last);
						$display("%0t:                  actual entry %0d code %0d clicks %0d last %0d",
							$time, seen.entry, seen.code, seen.clicks, seen.last);
					end
				end
				if ($urandom_range(0, 15) == 0)
					stall_on = !stall_on;
				stall_next = stall_on ? $urandom_range(0, 9) : 0;
			end else begin
				stall_next = (stall_left > 0) ? stall_left - 1 : 0;
			end
			stall_left  <= stall_next;
			ev_ch.ready <= (stall_next == 0);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("%0t: timeout with %0d events still expected", $time, pending_events.size());
			$display("FAIL");
			$finish;
		end
	end

	// Writes one register and updates the shadow copy.
	task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [15:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		if (idx < REG_DEBOUNCE_COUNT)
			mask_r[idx[1:0]] = value[2:0];
		else if (idx == REG_DEBOUNCE_COUNT)
			deb_cnt = value[7:0];
		else if (idx == REG_LONG_PRESS)
			lp_ticks = value;
		else if (idx == REG_CLICK_WINDOW)
			cw_ticks = value;
		else
			hold_iv = value[7:0];
		cfg_writes++;
	endtask

	task automatic set_masks(input logic [2:0] m0, input logic [2:0] m1,
		input logic [2:0] m2, input logic [2:0] m3);
		cfg_write(REG_ENTRY_MASK_0, {13'd0, m0});
		cfg_write(REG_ENTRY_MASK_0 + 3'd1, {13'd0, m1});
		cfg_write(REG_ENTRY_MASK_0 + 3'd2, {13'd0, m2});
		cfg_write(REG_ENTRY_MASK_0 + 3'd3, {13'd0, m3});
	endtask

	task automatic set_timing(input logic [7:0] deb, input logic [15:0] lp,
		input logic [15:0] cw, input logic [7:0] hold);
		cfg_write(REG_DEBOUNCE_COUNT, {8'd0, deb});
		cfg_write(REG_LONG_PRESS, lp);
		cfg_write(REG_CLICK_WINDOW, cw);
		cfg_write(REG_HOLD_INTERVAL, {8'd0, hold});
	endtask

	// Queues a run of identical ticks; a drain tick waits for all events first.
	function automatic void add_ticks(input logic [2:0] keys, input int n, input bit drain);
		scan_item_t it;
		for (int k = 0; k < n; k++) begin
			it.keys  = keys;
			it.gap   = idle_on ? $urandom_range(0, 9) : 0;
			it.drain = drain && (k == 0);
			scan_q.push_back(it);
		end
	endfunction

	// Waits until every tick is sent and every event has come, then lets the
	// block finish any tick that raised nothing.
	task automatic settle();
		while (scan_q.size() != 0 || staged_ok || key_ch.valid || pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Mostly press and release sequences on configured combos, some noise.
	task automatic random_phase(input int n_items);
		int         start;
		int         hold_max;
		int         rel_max;
		logic [2:0] pat;
		logic [2:0] rel;
		start = scan_q.size();
		while (scan_q.size() - start < n_items) begin
			if ($urandom_range(0, 15) == 0)
				idle_on = !idle_on;
			if ($urandom_range(0, 4) == 0) begin
				add_ticks(3'($urandom_range(0, 7)), $urandom_range(1, 4), 1'b0);
			end else begin
				pat = mask_r[$urandom_range(0, NUM_ENT - 1)];
				if ($urandom_range(0, 3) == 0)
					pat = pat | mask_r[$urandom_range(0, NUM_ENT - 1)];
				if (pat == 3'b000)
					pat = 3'($urandom_range(1, 7));
				hold_max = ((lp_ticks > 30) ? 30 : int'(lp_ticks)) + int'(deb_cnt) + 6;
				rel_max  = ((cw_ticks > 20) ? 20 : int'(cw_ticks)) + int'(deb_cnt) + 4;
				rel      = ($urandom_range(0, 3) == 0) ? (pat & 3'($urandom_range(0, 7))) : 3'b000;
				add_ticks(pat, $urandom_range(1, hold_max), $urandom_range(0, 9) == 0);
				add_ticks(rel, $urandom_range(1, rel_max), 1'b0);
			end
		end
		settle();
	endtask

	// Stimulus.
	initial begin
		arst_n          = 1'b0;
		key_ch.valid    = 1'b0;
		key_ch.raw_keys = 3'b000;
		ev_ch.ready     = 1'b0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = '0;
		cfg_ch.data     = '0;
		staged_ok       = 1'b0;
		idle_on         = 1'b1;
		stall_on        = 1'b1;
		errors          = 0;
		ticks_sent      = 0;
		events_seen     = 0;
		cfg_writes      = 0;
		cycles          = 0;
		deb_cnt         = RST_DEBOUNCE_COUNT;
		lp_ticks        = RST_LONG_PRESS;
		cw_ticks        = RST_CLICK_WINDOW;
		hold_iv         = RST_HOLD_INTERVAL;
		for (int e = 0; e < NUM_ENT; e++) begin
			mask_r[e]     = 3'b000;
			ent_state[e]  = ST_IDLE;
			held_ticks[e] = 16'd0;
			presses[e]    = 4'd0;
			bounce_run[e] = 8'd0;
			settled[e]    = 1'b0;
			hold_left[e]  = 8'd0;
			combo_mute[e] = 1'b0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Every entry is disabled after reset, so keys raise nothing.
		add_ticks(3'b111, 2, 1'b0);
		settle();

		// Directed: single keys, a two-key combo over both, and all keys.
		set_masks(3'b001, 3'b010, 3'b011, 3'b111);
		set_timing(8'd1, 16'd4, 16'd3, 8'd0);
		add_ticks(3'b000, 1, 1'b0);
		add_ticks(3'b001, 1, 1'b0);
		add_ticks(3'b000, 1, 1'b0);
		add_ticks(3'b001, 1, 1'b0);
		add_ticks(3'b000, 5, 1'b0);
		add_ticks(3'b010, 1, 1'b0);
		add_ticks(3'b000, 5, 1'b0);
		add_ticks(3'b011, 2, 1'b0);
		add_ticks(3'b000, 5, 1'b1);
		add_ticks(3'b111, 1, 1'b0);
		add_ticks(3'b000, 1, 1'b0);
		add_ticks(3'b111, 7, 1'b0);
		add_ticks(3'b000, 1, 1'b0);
		settle();

		// Random sequences under fixed timing settings, extremes included.
		for (int p = 0; p < 4; p++) begin
			set_masks(3'($urandom_range(1, 7)), 3'($urandom_range(0, 7)),
				3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
			case (p)
				0: set_timing(8'd2, 16'd6, 16'd4, 8'd1);
				1: set_timing(8'd0, 16'd0, 16'd0, 8'd0);
				2: set_timing(8'd3, 16'd20, 16'd10, 8'd255);
				default: begin
					set_timing(8'd1, 16'hFFFF, 16'hFFFF, 8'd3);
					// Rapid presses inside an endless window push the count to its cap.
					for (int k = 0; k < 18; k++) begin
						add_ticks(mask_r[0], 1, 1'b0);
						add_ticks(3'b000, 1, 1'b0);
					end
				end
			endcase
			random_phase(40);
		end

		// Long debounce: a level must persist for many samples.
		set_masks(3'b111, 3'b100, 3'b000, 3'b000);
		set_timing(8'd12, 16'hFFFF, 16'd5, 8'd255);
		add_ticks(3'b111, 14, 1'b0);
		add_ticks(3'b000, 16, 1'b0);
		settle();

		// Random timing; re-enabled entries resume from their frozen state.
		for (int p = 0; p < 2; p++) begin
			set_masks(3'($urandom_range(0, 7)), 3'($urandom_range(1, 7)),
				3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
			set_timing(8'($urandom_range(0, 4)), 16'($urandom_range(0, 30)),
				16'($urandom_range(0, 20)), 8'($urandom_range(0, 8)));
			random_phase(40);
		end

		$display("Run covered %0d scan ticks and %0d checked event beats over %0d register writes.",
			ticks_sent, events_seen, cfg_writes);
		$display("Mismatches or stray beats: %0d, expectations left: %0d.",
			errors, pending_events.size());
		if (errors == 0 && pending_events.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

[filelist.f]
src/bed_pkg.sv
src/bed_if.sv
src/bed_cfg_regs.sv
src/bed_entry_upd.sv
src/bed_seq.sv
src/button_event_detector_top.sv
src/bed_chk.sv
tb/button_event_detector_top_tb.sv
